@@ sv/http_request_header_framer_core_macros.svh @@
// Assertion macros used by the header framer top level.
`ifndef HTTP_REQUEST_HEADER_FRAMER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEADER_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/hrf_pkg.sv @@
// Types, constants and helper functions for the HTTP request header framer.
`timescale 1ns / 1ps

package hrf_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int LENGTH_WIDTH   = 32;
   localparam int BODY_WIDTH     = 32;
   localparam int CMP_WIDTH      = (LENGTH_WIDTH > BODY_WIDTH) ? LENGTH_WIDTH : BODY_WIDTH;
   localparam int ACC_WIDTH      = LENGTH_WIDTH + 4;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX  = '1;
   localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX  = '1;
   localparam logic [BODY_WIDTH-1:0]     BODY_MAX = '1;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic [3:0] KEY_LEN = 4'd14;

   typedef enum logic [3:0] {
      ST_RL           = 4'd0,
      ST_RL_CR        = 4'd1,
      ST_RL_CRLF      = 4'd2,
      ST_RL_CRLFCR    = 4'd3,
      ST_KEY          = 4'd4,
      ST_KEY_COLON    = 4'd5,
      ST_KEY_COLON_SP = 4'd6,
      ST_VALUE        = 4'd7,
      ST_VALUE_CR     = 4'd8,
      ST_VALUE_CRLF   = 4'd9,
      ST_VALUE_CRLFCR = 4'd10,
      ST_CONTENT      = 4'd11,
      ST_ERROR        = 4'd12
   } parse_state_type;

   typedef enum logic [1:0] {
      STAT_INCOMPLETE = 2'd0,
      STAT_DONE       = 2'd1,
      STAT_ERROR      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_FIRST_KEY = 3'd1,
      EV_KEY       = 3'd2,
      EV_VALUE     = 3'd3,
      EV_PAIR      = 3'd4,
      EV_BODY      = 3'd5
   } event_type;

   typedef struct packed {
      logic [7:0]                out_byte;
      logic [POSITION_WIDTH-1:0] byte_index;
      event_type                 event_res;
      logic [POSITION_WIDTH-1:0] stored_key_index;
      status_type                status;
      logic [LENGTH_WIDTH-1:0]   content_length;
      logic [POSITION_WIDTH-1:0] uri_start;
      logic [POSITION_WIDTH-1:0] body_start;
   } result_type;

   function automatic logic [POSITION_WIDTH-1:0] pos_inc(input logic [POSITION_WIDTH-1:0] p);
      pos_inc = (p != POS_MAX) ? p + 1'b1 : p;
   endfunction

   // "content-length", one character per match position
   function automatic logic [7:0] key_char_at(input logic [3:0] i);
      logic [7:0] c;
      case (i)
         4'd0:    c = 8'h63;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h6E;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6E;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2D;
         4'd8:    c = 8'h6C;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6E;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         default: c = 8'h00;
      endcase
      key_char_at = c;
   endfunction

   // acc * 10 + digit, saturating at the top of the length range
   function automatic logic [LENGTH_WIDTH-1:0] accum_digit(
      input logic [LENGTH_WIDTH-1:0] acc,
      input logic [3:0]              digit
   );
      logic [ACC_WIDTH-1:0] wide;
      logic [ACC_WIDTH-1:0] acc_x;
      acc_x = ACC_WIDTH'(acc);
      wide  = (acc_x << 3) + (acc_x << 1) + ACC_WIDTH'(digit);
      accum_digit = (wide > ACC_WIDTH'(LEN_MAX)) ? LEN_MAX : wide[LENGTH_WIDTH-1:0];
   endfunction

endpackage

@@ sv/hrf_parse_core.sv @@
// Per-byte header state machine, key matcher, length decoder and status logic.
`timescale 1ns / 1ps

module hrf_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   output hrf_pkg::result_type result
);

   hrf_pkg::parse_state_type                state_ff, state_in;
   hrf_pkg::status_type                     status_ff, status_in;
   logic [hrf_pkg::POSITION_WIDTH-1:0]      pos_ff, pos_in;
   logic [hrf_pkg::POSITION_WIDTH-1:0]      key_start_ff, key_start_in;
   logic [hrf_pkg::POSITION_WIDTH-1:0]      body_start_ff, body_start_in;
   logic [hrf_pkg::POSITION_WIDTH-1:0]      uri_start_ff, uri_start_in;
   logic [3:0]                              match_cnt_ff, match_cnt_in;
   logic                                    match_ok_ff, match_ok_in;
   logic                                    length_seen_ff, length_seen_in;
   logic [hrf_pkg::LENGTH_WIDTH-1:0]        accum_ff, accum_in;
   logic [1:0]                              space_cnt_ff, space_cnt_in;
   logic [hrf_pkg::BODY_WIDTH-1:0]          body_cnt_ff, body_cnt_in;

   logic [7:0]                              lc;
   logic [7:0]                              ob;
   logic                                    is_digit;
   logic                                    value_active;
   logic                                    lc_is_key0;
   logic [hrf_pkg::LENGTH_WIDTH-1:0]        clen;
   hrf_pkg::event_type                      ev;
   logic [hrf_pkg::POSITION_WIDTH-1:0]      stored;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hrf_pkg::ST_RL;
         status_ff      <= hrf_pkg::STAT_INCOMPLETE;
         pos_ff         <= '0;
         key_start_ff   <= '0;
         body_start_ff  <= '0;
         uri_start_ff   <= '0;
         match_cnt_ff   <= '0;
         match_ok_ff    <= 1'b0;
         length_seen_ff <= 1'b0;
         accum_ff       <= '0;
         space_cnt_ff   <= '0;
         body_cnt_ff    <= '0;
      end else if (fire) begin
         state_ff       <= state_in;
         status_ff      <= status_in;
         pos_ff         <= pos_in;
         key_start_ff   <= key_start_in;
         body_start_ff  <= body_start_in;
         uri_start_ff   <= uri_start_in;
         match_cnt_ff   <= match_cnt_in;
         match_ok_ff    <= match_ok_in;
         length_seen_ff <= length_seen_in;
         accum_ff       <= accum_in;
         space_cnt_ff   <= space_cnt_in;
         body_cnt_ff    <= body_cnt_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      pos_in         = pos_ff;
      key_start_in   = key_start_ff;
      body_start_in  = body_start_ff;
      uri_start_in   = uri_start_ff;
      match_cnt_in   = match_cnt_ff;
      match_ok_in    = match_ok_ff;
      length_seen_in = length_seen_ff;
      accum_in       = accum_ff;
      space_cnt_in   = space_cnt_ff;
      body_cnt_in    = body_cnt_ff;

      lc = (data_byte >= hrf_pkg::CH_UPPER_A && data_byte <= hrf_pkg::CH_UPPER_Z) ?
           data_byte + hrf_pkg::CASE_SHIFT : data_byte;
      ob           = data_byte;
      ev           = hrf_pkg::EV_NONE;
      stored       = '0;
      is_digit     = (data_byte >= hrf_pkg::CH_ZERO) && (data_byte <= hrf_pkg::CH_NINE);
      value_active = !length_seen_ff && match_ok_ff;
      lc_is_key0   = (lc == hrf_pkg::key_char_at(4'd0));

      if (status_ff == hrf_pkg::STAT_INCOMPLETE) begin
         state_in = hrf_pkg::ST_ERROR;
         pos_in   = hrf_pkg::pos_inc(pos_ff);
         if (data_byte == hrf_pkg::CH_SPACE) begin
            if (space_cnt_ff == 2'd0)
               uri_start_in = hrf_pkg::pos_inc(pos_ff);
            if (space_cnt_ff < 2'd2)
               space_cnt_in = space_cnt_ff + 2'd1;
         end

         case (state_ff)
            hrf_pkg::ST_RL: begin
               state_in = hrf_pkg::ST_RL;
               if (data_byte == hrf_pkg::CH_CR) begin
                  state_in = hrf_pkg::ST_RL_CR;
                  ob       = 8'h00;
               end
            end
            hrf_pkg::ST_RL_CR: begin
               if (data_byte == hrf_pkg::CH_LF)
                  state_in = hrf_pkg::ST_RL_CRLF;
            end
            hrf_pkg::ST_RL_CRLF, hrf_pkg::ST_VALUE_CRLF: begin
               if (data_byte == hrf_pkg::CH_CR) begin
                  state_in = (state_ff == hrf_pkg::ST_RL_CRLF) ?
                             hrf_pkg::ST_RL_CRLFCR : hrf_pkg::ST_VALUE_CRLFCR;
               end else begin
                  state_in     = hrf_pkg::ST_KEY;
                  ob           = lc;
                  ev           = (state_ff == hrf_pkg::ST_RL_CRLF) ?
                                 hrf_pkg::EV_FIRST_KEY : hrf_pkg::EV_KEY;
                  key_start_in = pos_ff;
                  match_ok_in  = lc_is_key0;
                  match_cnt_in = lc_is_key0 ? 4'd1 : 4'd0;
                  if (!length_seen_ff)
                     accum_in = '0;
               end
            end
            hrf_pkg::ST_RL_CRLFCR, hrf_pkg::ST_VALUE_CRLFCR: begin
               if (data_byte == hrf_pkg::CH_LF) begin
                  state_in      = hrf_pkg::ST_CONTENT;
                  ev            = hrf_pkg::EV_BODY;
                  body_start_in = hrf_pkg::pos_inc(pos_ff);
               end
            end
            hrf_pkg::ST_KEY: begin
               if (data_byte == hrf_pkg::CH_COLON) begin
                  state_in    = hrf_pkg::ST_KEY_COLON;
                  ob          = 8'h00;
                  match_ok_in = match_ok_ff && (match_cnt_ff == hrf_pkg::KEY_LEN);
               end else begin
                  state_in = hrf_pkg::ST_KEY;
                  ob       = lc;
                  if (match_ok_ff && match_cnt_ff < hrf_pkg::KEY_LEN &&
                      lc == hrf_pkg::key_char_at(match_cnt_ff))
                     match_cnt_in = match_cnt_ff + 4'd1;
                  else
                     match_ok_in = 1'b0;
               end
            end
            hrf_pkg::ST_KEY_COLON: begin
               if (data_byte == hrf_pkg::CH_SPACE)
                  state_in = hrf_pkg::ST_KEY_COLON_SP;
            end
            hrf_pkg::ST_KEY_COLON_SP, hrf_pkg::ST_VALUE: begin
               if (state_ff == hrf_pkg::ST_VALUE && data_byte == hrf_pkg::CH_CR) begin
                  state_in = hrf_pkg::ST_VALUE_CR;
                  ob       = 8'h00;
                  ev       = hrf_pkg::EV_PAIR;
                  stored   = key_start_ff;
                  if (match_ok_ff)
                     length_seen_in = 1'b1;
               end else begin
                  state_in = hrf_pkg::ST_VALUE;
                  if (state_ff == hrf_pkg::ST_KEY_COLON_SP)
                     ev = hrf_pkg::EV_VALUE;
                  if (value_active) begin
                     if (is_digit) begin
                        accum_in = hrf_pkg::accum_digit(accum_ff,
                                                        4'(data_byte - hrf_pkg::CH_ZERO));
                     end else begin
                        match_ok_in = 1'b0;
                        accum_in    = '0;
                     end
                  end
               end
            end
            hrf_pkg::ST_VALUE_CR: begin
               if (data_byte == hrf_pkg::CH_LF)
                  state_in = hrf_pkg::ST_VALUE_CRLF;
            end
            hrf_pkg::ST_CONTENT: begin
               state_in = hrf_pkg::ST_CONTENT;
               if (body_cnt_ff != hrf_pkg::BODY_MAX)
                  body_cnt_in = body_cnt_ff + 1'b1;
            end
            default: begin
               state_in = hrf_pkg::ST_ERROR;
            end
         endcase

         clen = length_seen_in ? accum_in : '0;
         if (state_in == hrf_pkg::ST_ERROR) begin
            status_in = hrf_pkg::STAT_ERROR;
         end else if (state_in == hrf_pkg::ST_CONTENT) begin
            if (clen == '0 ||
                hrf_pkg::CMP_WIDTH'(body_cnt_in) >= hrf_pkg::CMP_WIDTH'(clen))
               status_in = (space_cnt_in == 2'd2) ? hrf_pkg::STAT_DONE : hrf_pkg::STAT_ERROR;
         end
      end

      clen = length_seen_in ? accum_in : '0;

      result.out_byte         = ob;
      result.byte_index       = pos_ff;
      result.event_res        = ev;
      result.stored_key_index = stored;
      result.status           = status_in;
      result.content_length   = clen;
      result.uri_start        = (status_in == hrf_pkg::STAT_DONE) ? uri_start_in : '0;
      result.body_start       = body_start_in;
   end

endmodule

@@ sv/hrf_out_stage.sv @@
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps

module hrf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hrf_pkg::result_type result_in,
   input  logic                rsp_stall,
   output logic                ready,
   output logic                valid,
   output hrf_pkg::result_type result_out
);

   logic                valid_ff, valid_in;
   hrf_pkg::result_type result_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign valid      = valid_ff;
   assign result_out = result_ff;

endmodule

@@ sv/http_request_header_framer_core.sv @@
// Top level of the HTTP request header framer: input register, parser, result register.
`timescale 1ns / 1ps
`include "http_request_header_framer_core_macros.svh"

// Takes one request byte per transaction and returns one result transaction per byte:
// the byte lowercased in header keys or zeroed at the key colon and at the CR ending the
// request line or a value, its position, an event code, the decoded content-length and
// a sticky incomplete/done/error status. Sustained rate is one byte per clock while the
// response side does not stall. A byte passes two register stages, the input register
// and the result register; the whole per-byte parse step is evaluated combinationally
// between them. Both sides stall independently without losing or repeating a transaction.
module http_request_header_framer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic [hrf_pkg::POSITION_WIDTH-1:0]  rsp_byte_index,
   output logic [2:0]                          rsp_event_res,
   output logic [hrf_pkg::POSITION_WIDTH-1:0]  rsp_stored_key_index,
   output logic [1:0]                          rsp_status,
   output logic [hrf_pkg::LENGTH_WIDTH-1:0]    rsp_content_length,
   output logic [hrf_pkg::POSITION_WIDTH-1:0]  rsp_uri_start,
   output logic [hrf_pkg::POSITION_WIDTH-1:0]  rsp_body_start
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_ready;
   logic                advance;
   logic                req_take;
   hrf_pkg::result_type parse_result;
   hrf_pkg::result_type out_result;

   assign advance     = in_valid_ff && out_ready;
   assign req_stall   = in_valid_ff && !out_ready;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
   end

   hrf_parse_core u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .data_byte (in_byte_ff),
      .result    (parse_result)
   );

   hrf_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (parse_result),
      .rsp_stall  (rsp_stall),
      .ready      (out_ready),
      .valid      (rsp_valid),
      .result_out (out_result)
   );

   assign rsp_out_byte         = out_result.out_byte;
   assign rsp_byte_index       = out_result.byte_index;
   assign rsp_event_res        = 3'(out_result.event_res);
   assign rsp_stored_key_index = out_result.stored_key_index;
   assign rsp_status           = 2'(out_result.status);
   assign rsp_content_length   = out_result.content_length;
   assign rsp_uri_start        = out_result.uri_start;
   assign rsp_body_start       = out_result.body_start;

   `HRF_ASSERT_NEXT(a_done_sticky, clock, reset, rsp_valid && !rsp_stall && rsp_status == 2'(hrf_pkg::STAT_DONE), !rsp_valid || rsp_status == 2'(hrf_pkg::STAT_DONE), "done status not sticky")
   `HRF_ASSERT_NOW(a_uri_when_done, clock, reset, rsp_valid && rsp_status != 2'(hrf_pkg::STAT_DONE), rsp_uri_start == '0, "uri start shown before done")
   `HRF_ASSERT_NOW(a_stored_on_pair, clock, reset, rsp_valid && rsp_event_res != 3'(hrf_pkg::EV_PAIR), rsp_stored_key_index == '0, "stored key index outside pair event")
   `HRF_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff), "held input transaction lost")

endmodule
